// File: design/raycast_column_dda_unit_defines.svh
// ----------------------------------------------------------------------------
// Raycast column DDA unit - assertion macros
// Shared checks used by the modules of the raycast column unit.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_COLUMN_DDA_UNIT_DEFINES_SVH
`define RAYCAST_COLUMN_DDA_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Types and constants shared by the raycast column unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcd_pkg;

  // input function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACING        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH = 3'd5;

  // facing codes
  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_EAST  = 2'd1;
  localparam logic [1:0] FACE_SOUTH = 2'd2;
  localparam logic [1:0] FACE_WEST  = 2'd3;

  // register reset values
  localparam logic [4:0]  RST_PLAYER_X      = 5'd1;
  localparam logic [4:0]  RST_PLAYER_Y      = 5'd1;
  localparam logic [1:0]  RST_FACING        = FACE_NORTH;
  localparam logic [12:0] RST_VIEW_WIDTH    = 13'd640;
  localparam logic [12:0] RST_VIEW_HEIGHT   = 13'd480;
  localparam logic [10:0] RST_TEXTURE_WIDTH = 11'd64;

  // tan(30 deg) in 0.32 fixed point
  localparam logic [63:0] TAN30_Q32 = 64'd2479700525;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [4:0]  player_x;
    logic [4:0]  player_y;
    logic [1:0]  facing;
    logic [12:0] view_width;
    logic [12:0] view_height;
    logic [10:0] texture_width;
  } cfg_t;

  typedef struct packed {
    logic        is_cast;
    logic [4:0]  tile_col;
    logic [4:0]  tile_row;
    logic        tile_wall;
    logic [11:0] screen_column;
  } qentry_t;

  typedef struct packed {
    logic clearing;
    logic full;
  } fe_stall_t;

  typedef enum logic [4:0] {
    B_CLEAR, B_IDLE, B_LMUL, B_LGO, B_LWAIT, B_WALK, B_HMUL, B_NMUL1, B_NMUL2,
    B_HGO, B_HWAIT, B_MGO, B_MWAIT, B_TMUL, B_TGO, B_TWAIT, B_FIN
  } back_state_t;

endpackage

// File: design/rcd_ram.sv
// ----------------------------------------------------------------------------
// rcd_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/rcd_div.sv
// ----------------------------------------------------------------------------
// rcd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcd_div #(
  parameter int NW = 31,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  // one shift-subtract step
  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

// File: design/rcd_queue.sv
// ----------------------------------------------------------------------------
// rcd_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "raycast_column_dda_unit_defines.svh"

module rcd_queue
  import rcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t din,
  input  logic    pop,
  output qentry_t dout,
  output logic    empty,
  output logic    full
);

  localparam int QAW = $clog2(QDEPTH);

  qentry_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  assign dout  = mem[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));

  `RCD_ASSERT_NOW(a_no_push_full, push, !full || pop, "push into a full queue")
  `RCD_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after a push")

endmodule

// File: design/rcd_front.sv
// ----------------------------------------------------------------------------
// rcd_front
// Accepts input items, drops those that do nothing, queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcd_front
  import rcd_pkg::*;
#(
  parameter int MAP_COLS = 32,
  parameter int MAP_ROWS = 32
) (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [4:0]  tile_col,
  input  logic [4:0]  tile_row,
  input  logic        tile_wall,
  input  logic [11:0] screen_column,
  input  logic [12:0] view_width,
  input  fe_stall_t   stall,
  output logic        push,
  output qentry_t     entry
);

  logic keep;

  // classify: casts beyond the view and writes off the map are dropped
  always_comb begin
    if (func == FUNC_CAST) begin
      keep = ({1'b0, screen_column} < view_width);
    end else begin
      keep = (int'(tile_col) < MAP_COLS) && (int'(tile_row) < MAP_ROWS);
    end
  end

  assign in_ready = !stall.clearing && !stall.full;
  assign push     = in_valid && in_ready && keep;

  // queue entry
  always_comb begin
    entry.is_cast       = (func == FUNC_CAST);
    entry.tile_col      = tile_col;
    entry.tile_row      = tile_row;
    entry.tile_wall     = tile_wall;
    entry.screen_column = screen_column;
  end

endmodule

// File: design/rcd_back.sv
// ----------------------------------------------------------------------------
// rcd_back
// Executes queued items: map writes, ray setup, DDA walk and slice math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "raycast_column_dda_unit_defines.svh"

module rcd_back
  import rcd_pkg::*;
#(
  parameter int MAP_COLS  = 32,
  parameter int MAP_ROWS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  qentry_t     q_head,
  output logic        q_pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] column_out,
  output logic signed [6:0] hit_col,
  output logic signed [6:0] hit_row,
  output logic        hit_side,
  output logic [13:0] slice_height,
  output logic [12:0] slice_top,
  output logic [12:0] slice_bottom,
  output logic [9:0]  texel_column
);

  localparam int F     = FRAC_BITS;
  localparam int MAXD  = (MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS;
  localparam int XSPAN = (MAXD > 32) ? MAXD : 32;
  localparam int XW    = $clog2(XSPAN) + 2;
  localparam int LIM   = MAP_COLS + MAP_ROWS + 40;
  localparam int SW    = $clog2(LIM + 1);
  localparam int KW    = SW + 1;
  localparam int AMW   = F + 1;
  localparam int ACCW  = AMW + KW;
  localparam int NNW   = F + KW + 4;
  localparam int NW    = (F + 15 > NNW) ? F + 15 : NNW;
  localparam int DW    = (F + 2 > 14) ? F + 2 : 14;
  localparam int DEPTH = MAP_COLS * MAP_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAP_COLS);
  localparam int RWI   = $clog2(MAP_ROWS);
  localparam logic [63:0] T64 = (TAN30_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [F-1:0] TAN_F = T64[F-1:0];
  localparam logic signed [F+1:0] ONE_S = {2'b01, {F{1'b0}}};
  localparam logic signed [XW-1:0] MCOLS_S = XW'(MAP_COLS);
  localparam logic signed [XW-1:0] MROWS_S = XW'(MAP_ROWS);

  back_state_t state, state_next;

  // control and datapath registers
  logic [AW-1:0]          clr_addr;
  logic [11:0]            x_r;
  logic                   numneg_r;
  logic [F+13:0]          latp_r;
  logic signed [F+1:0]    rx_r, ry_r;
  logic [AMW-1:0]         arx_r, ary_r;
  logic [ACCW-1:0]        acc_a, acc_b;
  logic [SW-1:0]          i_r, j_r, steps_r;
  logic signed [XW-1:0]   mx_r, my_r;
  logic                   side_r, pend_r, outside_r;
  logic [DW+12:0]         hprod_r;
  logic [F+6:0]           t1_r;
  logic signed [NNW-1:0]  nn_r;
  logic [13:0]            lh_r;
  logic [DW-1:0]          remv_r;
  logic [DW+10:0]         tprod_r;
  logic [10:0]            tex_r;

  // combinational signals
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr, tile_addr;
  logic                   ram_wdata, rd_data;
  logic                   div_start, div_busy, div_done;
  logic [NW-1:0]          div_num, div_quo;
  logic [DW-1:0]          div_den, div_rem;
  logic                   out_load;
  logic signed [14:0]     num_s;
  logic [13:0]            abs_num;
  logic [F-1:0]           mag;
  logic signed [F+1:0]    lat_n, rx_n, ry_n;
  logic [AMW-1:0]         arx_n, ary_n;
  logic                   a_lt, hit, walk_end;
  logic signed [XW-1:0]   mx_n, my_n, dx, dy;
  logic                   outside_n;
  logic [CW-1:0]          col_n;
  logic [RWI-1:0]         row_n;
  logic [AMW-1:0]         a_sel;
  logic signed [F+1:0]    r_sel;
  logic [5:0]             p_odd;
  logic [SW-1:0]          kk;
  logic [KW-1:0]          kodd;
  logic [DW-1:0]          dd;
  logic                   nn_neg;
  logic [NNW-1:0]         nn_abs;
  logic                   mirror;
  logic [10:0]            q_tex;
  logic signed [14:0]     top_s;
  logic [13:0]            bot_u;

  // map memory
  rcd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // shared divider
  rcd_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // lateral ray part and ray components
  always_comb begin
    num_s   = $signed({2'b0, x_r, 1'b0}) - $signed({2'b0, cfg.view_width});
    abs_num = num_s[14] ? 14'(-num_s) : num_s[13:0];
    mag     = div_quo[F-1:0];
    lat_n   = numneg_r ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
    case (cfg.facing)
      FACE_NORTH: begin rx_n = lat_n;  ry_n = -ONE_S; end
      FACE_EAST:  begin rx_n = ONE_S;  ry_n = lat_n;  end
      FACE_SOUTH: begin rx_n = -lat_n; ry_n = ONE_S;  end
      default:    begin rx_n = -ONE_S; ry_n = -lat_n; end
    endcase
    arx_n = rx_n[F+1] ? AMW'(-rx_n) : rx_n[F:0];
    ary_n = ry_n[F+1] ? AMW'(-ry_n) : ry_n[F:0];
  end

  // one DDA step and the address of the cell it enters
  always_comb begin
    a_lt      = (acc_a < acc_b);
    dx        = rx_r[F+1] ? $signed({XW{1'b1}}) : XW'(1);
    dy        = ry_r[F+1] ? $signed({XW{1'b1}}) : XW'(1);
    mx_n      = a_lt ? mx_r + dx : mx_r;
    my_n      = a_lt ? my_r : my_r + dy;
    outside_n = (mx_n < 0) || (mx_n >= MCOLS_S) || (my_n < 0) || (my_n >= MROWS_S);
    col_n     = mx_n[CW-1:0];
    row_n     = my_n[RWI-1:0];
    ram_raddr = AW'(row_n) * AW'(MAP_COLS) + AW'(col_n);
    hit       = outside_r || rd_data;
    walk_end  = pend_r && (hit || (steps_r == SW'(LIM)));
    tile_addr = AW'(q_head.tile_row) * AW'(MAP_COLS) + AW'(q_head.tile_col);
  end

  // distance, hit point and slice terms for the crossed side
  always_comb begin
    a_sel  = side_r ? ary_r : arx_r;
    r_sel  = side_r ? rx_r : ry_r;
    p_odd  = side_r ? {cfg.player_x, 1'b1} : {cfg.player_y, 1'b1};
    kk     = side_r ? j_r : i_r;
    kodd   = (kk == '0) ? KW'(1) : {kk, 1'b0} - KW'(1);
    dd     = DW'({a_sel, 1'b0});
    nn_neg = nn_r[NNW-1];
    nn_abs = nn_neg ? NNW'(-nn_r) : NNW'(nn_r);
    mirror = side_r ? ry_r[F+1] : (!rx_r[F+1] && (rx_r != '0));
    q_tex  = div_quo[10:0];
    top_s  = $signed({3'b0, cfg.view_height[12:1]}) - $signed({2'b0, lh_r[13:1]});
    bot_u  = {2'b0, cfg.view_height[12:1]} + {1'b0, lh_r[13:1]};
  end

  // next state and control
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.is_cast) begin
            state_next = B_LMUL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tile_addr;
            ram_wdata = q_head.tile_wall;
          end
        end
      end
      B_LMUL: state_next = B_LGO;
      B_LGO: begin
        div_start  = 1'b1;
        div_num    = NW'({latp_r, 1'b0}) + NW'(cfg.view_width);
        div_den    = DW'({cfg.view_width, 1'b0});
        state_next = B_LWAIT;
      end
      B_LWAIT: begin
        if (div_done) begin
          state_next = B_WALK;
        end
      end
      B_WALK: begin
        if (walk_end) begin
          state_next = B_HMUL;
        end
      end
      B_HMUL:  state_next = B_NMUL1;
      B_NMUL1: state_next = B_NMUL2;
      B_NMUL2: state_next = B_HGO;
      B_HGO: begin
        div_start  = 1'b1;
        div_num    = NW'(hprod_r >> F);
        div_den    = DW'(kodd);
        state_next = B_HWAIT;
      end
      B_HWAIT: begin
        if (div_done) begin
          if ((a_sel != '0) && (cfg.texture_width != '0)) begin
            state_next = B_MGO;
          end else begin
            state_next = B_FIN;
          end
        end
      end
      B_MGO: begin
        div_start  = 1'b1;
        div_num    = NW'(nn_abs);
        div_den    = dd;
        state_next = B_MWAIT;
      end
      B_MWAIT: begin
        if (div_done) begin
          state_next = B_TMUL;
        end
      end
      B_TMUL: state_next = B_TGO;
      B_TGO: begin
        div_start  = 1'b1;
        div_num    = NW'(tprod_r);
        div_den    = dd;
        state_next = B_TWAIT;
      end
      B_TWAIT: begin
        if (div_done) begin
          state_next = B_FIN;
        end
      end
      B_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // state, clear sweep and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty && q_head.is_cast) begin
          x_r <= q_head.screen_column;
        end
      end
      B_LMUL: begin
        latp_r   <= TAN_F * abs_num;
        numneg_r <= num_s[14];
      end
      B_LWAIT: begin
        if (div_done) begin
          rx_r    <= rx_n;
          ry_r    <= ry_n;
          arx_r   <= arx_n;
          ary_r   <= ary_n;
          acc_a   <= ACCW'(ary_n);
          acc_b   <= ACCW'(arx_n);
          i_r     <= '0;
          j_r     <= '0;
          steps_r <= '0;
          mx_r    <= $signed(XW'(cfg.player_x));
          my_r    <= $signed(XW'(cfg.player_y));
          side_r  <= 1'b0;
          pend_r  <= 1'b0;
        end
      end
      B_WALK: begin
        if (!walk_end) begin
          if (a_lt) begin
            i_r    <= i_r + SW'(1);
            acc_a  <= acc_a + ACCW'({ary_r, 1'b0});
            side_r <= 1'b0;
          end else begin
            j_r    <= j_r + SW'(1);
            acc_b  <= acc_b + ACCW'({arx_r, 1'b0});
            side_r <= 1'b1;
          end
          mx_r      <= mx_n;
          my_r      <= my_n;
          steps_r   <= steps_r + SW'(1);
          pend_r    <= 1'b1;
          outside_r <= outside_n;
        end
      end
      B_HMUL:  hprod_r <= cfg.view_height * dd;
      B_NMUL1: t1_r <= p_odd * a_sel;
      B_NMUL2: nn_r <= $signed({1'b0, t1_r}) + $signed({1'b0, kodd}) * r_sel;
      B_HWAIT: begin
        if (div_done) begin
          lh_r  <= div_quo[13:0];
          tex_r <= '0;
        end
      end
      B_MWAIT: begin
        if (div_done) begin
          remv_r <= (nn_neg && (div_rem != '0)) ? dd - div_rem : div_rem;
        end
      end
      B_TMUL: tprod_r <= remv_r * cfg.texture_width;
      B_TWAIT: begin
        if (div_done) begin
          tex_r <= mirror ? cfg.texture_width - q_tex - 11'd1 : q_tex;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      column_out   <= x_r;
      hit_col      <= mx_r[6:0];
      hit_row      <= my_r[6:0];
      hit_side     <= side_r;
      slice_height <= lh_r;
      slice_top    <= top_s[14] ? 13'd0 : top_s[12:0];
      slice_bottom <= (bot_u > {1'b0, cfg.view_height}) ? cfg.view_height : bot_u[12:0];
      texel_column <= tex_r[9:0];
    end
  end

  assign clearing = (state == B_CLEAR);

  `RCD_ASSERT_NOW(a_div_idle, div_start, !div_busy, "divider started while busy")
  `RCD_ASSERT_NOW(a_no_pop_clear, state == B_CLEAR, !q_pop, "item taken during map clear")
  `RCD_ASSERT_NOW(a_out_free, out_load, !out_valid || out_ready, "result overwrote a pending one")

endmodule

// File: design/raycast_column_dda_unit.sv
// ----------------------------------------------------------------------------
// raycast_column_dda_unit
// Column raycaster over a tile map of wall bits, DDA walk per screen column.
// ----------------------------------------------------------------------------
// After reset the map is cleared one cell per cycle, and no item is taken
// meanwhile; configuration writes are taken at any time. A tile write is
// done in the back end as it is taken from the queue. For a cast the shared
// one-bit-per-cycle divider runs up to four passes (lateral ray part, slice
// height, hit point fraction, texel column; the last two are skipped when the
// ray component for the crossed side or texture_width is zero) and the DDA
// walk visits one cell per cycle through the registered map read port. Casts
// at or beyond view_width and writes off the map are dropped at the front and
// give no result. A four-entry queue between front and back and an output
// register let input and output stall independently.
`timescale 1ns / 1ps

module raycast_column_dda_unit
  import rcd_pkg::*;
#(
  parameter int MAP_COLS  = 32,
  parameter int MAP_ROWS  = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [4:0]  tile_col,
  input  logic [4:0]  tile_row,
  input  logic        tile_wall,
  input  logic [11:0] screen_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] column_out,
  output logic signed [6:0] hit_col,
  output logic signed [6:0] hit_row,
  output logic        hit_side,
  output logic [13:0] slice_height,
  output logic [12:0] slice_top,
  output logic [12:0] slice_bottom,
  output logic [9:0]  texel_column,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  fe_stall_t stall;
  logic      push, pop, q_empty, q_full, clearing;
  qentry_t   entry, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.player_x      <= RST_PLAYER_X;
      cfg.player_y      <= RST_PLAYER_Y;
      cfg.facing        <= RST_FACING;
      cfg.view_width    <= RST_VIEW_WIDTH;
      cfg.view_height   <= RST_VIEW_HEIGHT;
      cfg.texture_width <= RST_TEXTURE_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLAYER_X:      cfg.player_x      <= cfg_data[4:0];
        CFG_PLAYER_Y:      cfg.player_y      <= cfg_data[4:0];
        CFG_FACING:        cfg.facing        <= cfg_data[1:0];
        CFG_VIEW_WIDTH:    cfg.view_width    <= cfg_data[12:0];
        CFG_VIEW_HEIGHT:   cfg.view_height   <= cfg_data[12:0];
        CFG_TEXTURE_WIDTH: cfg.texture_width <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready      = 1'b1;
  assign stall.clearing = clearing;
  assign stall.full     = q_full;

  // accept and classify
  rcd_front #(.MAP_COLS(MAP_COLS), .MAP_ROWS(MAP_ROWS)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .tile_col      (tile_col),
    .tile_row      (tile_row),
    .tile_wall     (tile_wall),
    .screen_column (screen_column),
    .view_width    (cfg.view_width),
    .stall         (stall),
    .push          (push),
    .entry         (entry)
  );

  // decoupling queue
  rcd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // execution
  rcd_back #(.MAP_COLS(MAP_COLS), .MAP_ROWS(MAP_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_head       (head),
    .q_pop        (pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .column_out   (column_out),
    .hit_col      (hit_col),
    .hit_row      (hit_row),
    .hit_side     (hit_side),
    .slice_height (slice_height),
    .slice_top    (slice_top),
    .slice_bottom (slice_bottom),
    .texel_column (texel_column)
  );

endmodule
